// File: rtl/core/i2c_cds_pkg.sv
// Types, constants and sequencer program for the bus clock divider search.
`timescale 1ns / 1ps

package i2c_cds_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned MANT_W   = 4;
	localparam int unsigned EXP_W    = 3;
	localparam int unsigned CWORD_W  = MANT_W + EXP_W;
	localparam int unsigned DVSR_W   = 8;
	localparam int unsigned STEP_W   = 3;
	localparam int unsigned BITCNT_W = 5;
	localparam int unsigned ADDR_W   = 3;

	localparam logic [DATA_W-1:0]   CLOCK_RESET_HZ = 32'd24000000;
	localparam logic [MANT_W-1:0]   DEFAULT_MANT   = 4'd5;
	localparam logic [EXP_W-1:0]    DEFAULT_EXP    = 3'd0;
	localparam logic [DVSR_W-1:0]   BASE_DIVISOR   = 8'd10;
	localparam logic [BITCNT_W-1:0] LAST_BIT       = 5'd31;

	// register byte address bit 2 upwards selects the register
	localparam logic REG_PCLK = 1'b0;

	localparam logic [STEP_W-1:0] STEP_IDLE    = 3'd0;
	localparam logic [STEP_W-1:0] STEP_LOAD    = 3'd1;
	localparam logic [STEP_W-1:0] STEP_DIV     = 3'd2;
	localparam logic [STEP_W-1:0] STEP_CMP     = 3'd3;
	localparam logic [STEP_W-1:0] STEP_LOADDEF = 3'd4;
	localparam logic [STEP_W-1:0] STEP_DIVDEF  = 3'd5;
	localparam logic [STEP_W-1:0] STEP_FIN     = 3'd6;
	localparam logic [STEP_W-1:0] STEP_EMIT    = 3'd7;

	typedef enum logic [2:0] {
		OP_INIT,
		OP_LOAD,
		OP_DIV,
		OP_CMP,
		OP_LOADDEF,
		OP_FIN,
		OP_EMIT
	} uop_t;

	typedef enum logic [2:0] {
		JC_NEVER,
		JC_NO_IN,
		JC_DIV_BUSY,
		JC_MORE_PAIRS,
		JC_HAVE,
		JC_OUT_BLOCKED
	} jcond_t;

	typedef struct packed {
		uop_t              op;
		jcond_t            cond;
		logic [STEP_W-1:0] target;
	} ucode_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		case (step)
			STEP_IDLE:    w = '{op: OP_INIT,    cond: JC_NO_IN,       target: STEP_IDLE};
			STEP_LOAD:    w = '{op: OP_LOAD,    cond: JC_NEVER,       target: STEP_IDLE};
			STEP_DIV:     w = '{op: OP_DIV,     cond: JC_DIV_BUSY,    target: STEP_DIV};
			STEP_CMP:     w = '{op: OP_CMP,     cond: JC_MORE_PAIRS,  target: STEP_LOAD};
			STEP_LOADDEF: w = '{op: OP_LOADDEF, cond: JC_HAVE,        target: STEP_FIN};
			STEP_DIVDEF:  w = '{op: OP_DIV,     cond: JC_DIV_BUSY,    target: STEP_DIVDEF};
			STEP_FIN:     w = '{op: OP_FIN,     cond: JC_NEVER,       target: STEP_IDLE};
			STEP_EMIT:    w = '{op: OP_EMIT,    cond: JC_OUT_BLOCKED, target: STEP_EMIT};
			default:      w = '{op: OP_INIT,    cond: JC_NEVER,       target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/i2c_clock_divider_search_top.sv
// Bus clock divider search: microcoded sequencer around a shared bit-serial divider.
//
//  channel   signals                           direction  beat
//  in        in_valid/in_stall, wanted_rate_hz  to block   one wanted rate
//  out       out_valid/out_stall, result fields from block one divider choice
//  cfg       psel/penable/pwrite/paddr/pwdata   to block   peripheral_clock_hz
//
// When no pair qualifies, a further divide computes the rate of the default pair.
// Each candidate costs one load, a restoring division over all 32 quotient bits
// and one compare; the divider is the single shared unit.
// One item at a time; in_stall is high while the sequencer is busy.
// Result sits in an output register; the next item is taken while it waits.
// Reset restores peripheral_clock_hz to 24 MHz and empties the output register.
`timescale 1ns / 1ps

module i2c_clock_divider_search_top
	import i2c_cds_pkg::*;
#(
	parameter int unsigned MANTISSA_STEPS = 16,
	parameter int unsigned EXPONENT_STEPS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [DATA_W-1:0]  wanted_rate_hz,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [MANT_W-1:0]  mantissa,
	output logic [EXP_W-1:0]   exponent,
	output logic [DATA_W-1:0]  achieved_hz,
	output logic               found,
	output logic [CWORD_W-1:0] control_word
);

	localparam logic [MANT_W-1:0] MANT_LAST = MANT_W'(MANTISSA_STEPS - 1);
	localparam logic [EXP_W-1:0]  EXP_LAST  = EXP_W'(EXPONENT_STEPS - 1);

	logic [STEP_W-1:0]   step_q;
	logic [DATA_W-1:0]   pclk_q;
	logic                have_q;
	logic [MANT_W-1:0]   m_q;
	logic [EXP_W-1:0]    n_q;
	logic [BITCNT_W-1:0] cnt_q;
	logic                out_valid_q;

	logic [DATA_W-1:0]   rate_q;
	logic [DATA_W-1:0]   quo_q;
	logic [DVSR_W-1:0]   rem_q;
	logic [DVSR_W-1:0]   dvsr_q;
	logic [DATA_W-1:0]   best_q;
	logic [MANT_W-1:0]   bm_q;
	logic [EXP_W-1:0]    bn_q;
	logic [DATA_W-1:0]   bf_q;
	logic [MANT_W-1:0]   mant_q;
	logic [EXP_W-1:0]    exp_q;
	logic [DATA_W-1:0]   ach_q;
	logic                found_q;

	ucode_t              uw;
	logic                jump;
	logic                in_acc;
	logic                last_pair;
	logic                out_blocked;
	logic                cfg_wr;
	logic [DVSR_W:0]     trial;
	logic                trial_ge;
	logic [DATA_W-1:0]   diff;
	logic                better;
	logic [DVSR_W-1:0]   cand_dvsr;

	assign uw          = ucode_rom(step_q);
	assign in_stall    = (step_q != STEP_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign last_pair   = (m_q == MANT_LAST) && (n_q == EXP_LAST);
	assign out_blocked = out_valid_q && out_stall;

	always_comb begin
		case (uw.cond)
			JC_NEVER:       jump = 1'b0;
			JC_NO_IN:       jump = !in_valid;
			JC_DIV_BUSY:    jump = (cnt_q != LAST_BIT);
			JC_MORE_PAIRS:  jump = !last_pair;
			JC_HAVE:        jump = have_q;
			JC_OUT_BLOCKED: jump = out_blocked;
			default:        jump = 1'b0;
		endcase
	end

	// restoring divider, one quotient bit per cycle
	assign trial     = {rem_q, quo_q[DATA_W-1]};
	assign trial_ge  = (trial >= {1'b0, dvsr_q});
	assign diff      = rate_q - quo_q;
	assign better    = (quo_q <= rate_q) && (!have_q || (diff < best_q));
	assign cand_dvsr = DVSR_W'(({4'd0, m_q} + 8'd1) * BASE_DIVISOR);

	assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_PCLK);
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_PCLK) ? pclk_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_IDLE;
			pclk_q      <= CLOCK_RESET_HZ;
			have_q      <= 1'b0;
			m_q         <= '0;
			n_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				pclk_q <= pwdata;
			end
			step_q <= jump ? uw.target : step_q + STEP_W'(1);
			if ((uw.op == OP_EMIT) && !out_blocked) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (uw.op)
				OP_INIT: begin
					if (in_valid) begin
						have_q <= 1'b0;
						m_q    <= '0;
						n_q    <= '0;
					end
				end
				OP_LOAD:    cnt_q <= '0;
				OP_LOADDEF: cnt_q <= '0;
				OP_DIV:     cnt_q <= cnt_q + BITCNT_W'(1);
				OP_CMP: begin
					if (better) begin
						have_q <= 1'b1;
					end
					if (m_q == MANT_LAST) begin
						m_q <= '0;
						n_q <= n_q + EXP_W'(1);
					end else begin
						m_q <= m_q + MANT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (uw.op)
			OP_INIT: begin
				if (in_acc) begin
					rate_q <= wanted_rate_hz;
				end
			end
			OP_LOAD: begin
				quo_q  <= pclk_q >> n_q;
				rem_q  <= '0;
				dvsr_q <= cand_dvsr;
			end
			OP_LOADDEF: begin
				quo_q  <= pclk_q >> DEFAULT_EXP;
				rem_q  <= '0;
				dvsr_q <= DVSR_W'(({4'd0, DEFAULT_MANT} + 8'd1) * BASE_DIVISOR);
			end
			OP_DIV: begin
				quo_q <= {quo_q[DATA_W-2:0], trial_ge};
				rem_q <= trial_ge ? DVSR_W'(trial - {1'b0, dvsr_q}) : trial[DVSR_W-1:0];
			end
			OP_CMP: begin
				if (better) begin
					best_q <= diff;
					bm_q   <= m_q;
					bn_q   <= n_q;
					bf_q   <= quo_q;
				end
			end
			OP_FIN: begin
				if (!have_q) begin
					bm_q <= DEFAULT_MANT;
					bn_q <= DEFAULT_EXP;
					bf_q <= quo_q;
				end
			end
			OP_EMIT: begin
				if (!out_blocked) begin
					mant_q  <= bm_q;
					exp_q   <= bn_q;
					ach_q   <= bf_q;
					found_q <= have_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign mantissa     = mant_q;
	assign exponent     = exp_q;
	assign achieved_hz  = ach_q;
	assign found        = found_q;
	assign control_word = {mant_q, exp_q};

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (step_q == STEP_LOAD))
		else $error("accepted beat did not start the search");

	a_default_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (mantissa == DEFAULT_MANT && exponent == DEFAULT_EXP))
		else $error("no-match result lacks default pair");

	a_best_at_or_below: assert property (@(posedge clk) disable iff (!arst_n)
		(have_q && (step_q == STEP_FIN)) |-> (bf_q <= rate_q))
		else $error("chosen rate above wanted rate");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_DIV) |-> (rem_q < dvsr_q))
		else $error("divider remainder out of range");

	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		((step_q == STEP_EMIT) && !out_blocked) |=> (out_valid && step_q == STEP_IDLE))
		else $error("result not presented after search");
`endif

endmodule
